[hdl/ktdc_pkg.sv]
// Shared constants, types and helpers of the key tree destination counter.
package ktdc_pkg;

   localparam int NODE_COUNT = 1024;
   localparam int LEAF_COUNT = 1024;
   localparam int TASK_COUNT = 256;
   localparam int MAX_DEPTH  = 22;
   localparam int COUNT_BITS = 32;

   localparam int NODE_AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int LEAF_AW  = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;
   localparam int TASK_AW  = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);

   // Wide enough to compare any index field against the largest table depth.
   localparam int CMP_W    = 18;

   localparam int KEY_W    = 63;
   localparam int DIV_W    = 60;
   // Quotient bits that can still give a child below NODE_COUNT.
   localparam int Q_W      = NODE_AW;
   localparam int STEP_W   = (Q_W > 1) ? $clog2(Q_W) : 1;
   localparam int WIDE_W   = KEY_W + Q_W;
   localparam int CHILD_W  = ((Q_W > 10) ? Q_W : 10) + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam int OP_W        = 3;
   localparam int REQ_DATA_W  = 256;
   localparam int RSP_DATA_W  = 152;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_TASK = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STAR_EN    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLE_EN    = 2'd2;

   localparam logic [2:0] TYPE_GAS  = 3'd0;
   localparam logic [2:0] TYPE_STAR = 3'd4;
   localparam logic [2:0] TYPE_HOLE = 3'd5;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE_NODE   = 3'd0,
      OP_WRITE_LEAF   = 3'd1,
      OP_CLASSIFY     = 3'd2,
      OP_READ_COUNTS  = 3'd3,
      OP_CLEAR_COUNTS = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      KIND_NODE,
      KIND_LEAF,
      KIND_WALK,
      KIND_QUERY,
      KIND_CLEAR,
      KIND_NONE
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              in_range;
      logic [9:0]        node_index;
      logic [10:0]       daughter;
      logic [KEY_W-1:0]  start_key;
      logic [KEY_W-1:0]  size;
      logic [9:0]        node_leaf;
      logic [9:0]        leaf_index;
      logic [7:0]        leaf_task;
      logic [KEY_W-1:0]  key;
      logic [2:0]        ptype;
      logic [7:0]        task_query;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_link_type;

   typedef struct packed {
      logic [7:0] local_task;
      logic       star_en;
      logic       hole_en;
   } cfg_type;

   typedef struct packed {
      logic        walk_error;
      logic [31:0] count_hole;
      logic [31:0] count_star;
      logic [31:0] count_gas;
      logic [31:0] count_total;
      logic        is_remote;
      logic [9:0]  dest_leaf;
      logic [7:0]  dest_task;
   } result_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] hole;
      logic [COUNT_BITS-1:0] star;
      logic [COUNT_BITS-1:0] gas;
      logic [COUNT_BITS-1:0] total;
   } cnt_set_type;

   typedef struct packed {
      logic [10:0]      daughter;
      logic [KEY_W-1:0] start_key;
      logic [KEY_W-1:0] size;
      logic [9:0]       leaf;
   } node_entry_type;

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c,
                                                  input logic hit);
      logic [COUNT_BITS-1:0] r;
      r = c;
      if (hit && (c != COUNT_MAX)) begin
         r = c + 1'b1;
      end
      return r;
   endfunction

endpackage

[hdl/ktdc_front.sv]
// Front end: accepts request transactions, classifies them and queues them.
module ktdc_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ktdc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [ktdc_pkg::OP_W-1:0]        req_tuser,
   input  logic                             q_pop,
   output ktdc_pkg::q_link_type             q_out
);

   ktdc_pkg::item_type                    dec;
   ktdc_pkg::item_type                    q_mem_ff [ktdc_pkg::QUEUE_DEPTH];
   logic [ktdc_pkg::QUEUE_AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [ktdc_pkg::QUEUE_AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [ktdc_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic                                  push;
   logic                                  pop;

   always_comb begin
      dec.node_index = req_tdata[9:0];
      dec.daughter   = req_tdata[20:10];
      dec.start_key  = req_tdata[83:21];
      dec.size       = req_tdata[146:84];
      dec.node_leaf  = req_tdata[156:147];
      dec.leaf_index = req_tdata[166:157];
      dec.leaf_task  = req_tdata[174:167];
      dec.key        = req_tdata[237:175];
      dec.ptype      = req_tdata[240:238];
      dec.task_query = req_tdata[248:241];
      dec.in_range   = 1'b1;
      case (req_tuser)
         ktdc_pkg::OP_WRITE_NODE: begin
            dec.kind     = ktdc_pkg::KIND_NODE;
            dec.in_range = ktdc_pkg::CMP_W'(dec.node_index)
                           < ktdc_pkg::CMP_W'(ktdc_pkg::NODE_COUNT);
         end
         ktdc_pkg::OP_WRITE_LEAF: begin
            dec.kind     = ktdc_pkg::KIND_LEAF;
            dec.in_range = ktdc_pkg::CMP_W'(dec.leaf_index)
                           < ktdc_pkg::CMP_W'(ktdc_pkg::LEAF_COUNT);
         end
         ktdc_pkg::OP_CLASSIFY: begin
            dec.kind = ktdc_pkg::KIND_WALK;
         end
         ktdc_pkg::OP_READ_COUNTS: begin
            dec.kind     = ktdc_pkg::KIND_QUERY;
            dec.in_range = ktdc_pkg::CMP_W'(dec.task_query)
                           < ktdc_pkg::CMP_W'(ktdc_pkg::TASK_COUNT);
         end
         ktdc_pkg::OP_CLEAR_COUNTS: begin
            dec.kind = ktdc_pkg::KIND_CLEAR;
         end
         default: begin
            dec.kind = ktdc_pkg::KIND_NONE;
         end
      endcase
   end

   assign req_tready  = (count_ff != ktdc_pkg::QUEUE_CNT_W'(ktdc_pkg::QUEUE_DEPTH));
   assign push        = req_tvalid && req_tready;
   assign pop         = q_pop && (count_ff != '0);
   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = q_mem_ff[rd_ptr_ff];

   // The queue depth is a power of two, so the pointers wrap on their own.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

[hdl/ktdc_back.sv]
// Back end: table writes, tree walk with a serial divider, counters and results.
module ktdc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ktdc_pkg::q_link_type  q_in,
   output logic                  q_pop,
   input  ktdc_pkg::cfg_type     cfg,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ktdc_pkg::result_type  rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NODE_RD,
      ST_NODE_EVAL,
      ST_DIV_CHK,
      ST_DIV,
      ST_CHILD,
      ST_LEAF_RD,
      ST_LEAF_EVAL,
      ST_CNT_RD,
      ST_CNT_UPD,
      ST_QUERY_RD,
      ST_QUERY_OUT,
      ST_ERR
   } state_type;

   state_type                         state_ff, state_in;
   ktdc_pkg::item_type                item_ff, item_in;
   logic [ktdc_pkg::NODE_AW-1:0]      node_ff, node_in;
   logic [ktdc_pkg::DEPTH_W-1:0]      depth_ff, depth_in;
   logic [ktdc_pkg::KEY_W-1:0]        rem_ff, rem_in;
   logic [ktdc_pkg::WIDE_W-1:0]       dsh_ff, dsh_in;
   logic [ktdc_pkg::Q_W-1:0]          quo_ff, quo_in;
   logic [ktdc_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [9:0]                        leaf_ff, leaf_in;
   logic [7:0]                        task_ff, task_in;
   logic [ktdc_pkg::TASK_AW-1:0]      cnt_addr_ff, cnt_addr_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   ktdc_pkg::result_type              rsp_data_ff, rsp_data_in;

   ktdc_pkg::node_entry_type          node_mem [ktdc_pkg::NODE_COUNT];
   ktdc_pkg::node_entry_type          node_rd_ff;
   logic [7:0]                        leaf_mem [ktdc_pkg::LEAF_COUNT];
   logic [7:0]                        leaf_rd_ff;
   ktdc_pkg::cnt_set_type             cnt_mem [ktdc_pkg::TASK_COUNT];
   ktdc_pkg::cnt_set_type             cnt_rd_ff;
   logic [ktdc_pkg::TASK_COUNT-1:0]   cnt_vld_ff;
   logic                              cnt_vld_rd_ff;

   logic                              node_we, leaf_we, cnt_we, cnt_clear;
   ktdc_pkg::node_entry_type          node_wdata;
   ktdc_pkg::cnt_set_type             cnt_wdata, cnt_base;
   logic [ktdc_pkg::CMP_W-1:0]        node_widx, leaf_widx, leaf_ridx;
   logic [ktdc_pkg::CMP_W-1:0]        task_ext, query_ext;
   logic [63:0]                       diff;
   logic [ktdc_pkg::DIV_W-1:0]        divisor;
   logic [ktdc_pkg::CHILD_W-1:0]      child;
   logic                              out_free;
   logic                              fits;
   ktdc_pkg::result_type              res;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign node_widx = ktdc_pkg::CMP_W'(q_in.item.node_index);
   assign leaf_widx = ktdc_pkg::CMP_W'(q_in.item.leaf_index);
   assign leaf_ridx = ktdc_pkg::CMP_W'(leaf_ff);
   assign task_ext  = ktdc_pkg::CMP_W'(leaf_rd_ff);
   assign query_ext = ktdc_pkg::CMP_W'(q_in.item.task_query);
   assign diff      = {1'b0, item_ff.key} - {1'b0, node_rd_ff.start_key};
   assign divisor   = node_rd_ff.size[ktdc_pkg::KEY_W-1:3];
   assign child     = ktdc_pkg::CHILD_W'(node_rd_ff.daughter[9:0])
                      + ktdc_pkg::CHILD_W'(quo_ff);
   assign fits      = ktdc_pkg::WIDE_W'(rem_ff) >= dsh_ff;
   assign cnt_base  = cnt_vld_rd_ff ? cnt_rd_ff : '0;

   always_comb begin
      node_wdata.daughter  = q_in.item.daughter;
      node_wdata.start_key = q_in.item.start_key;
      node_wdata.size      = q_in.item.size;
      node_wdata.leaf      = q_in.item.node_leaf;
      cnt_wdata.total = ktdc_pkg::bump(cnt_base.total, 1'b1);
      cnt_wdata.gas   = ktdc_pkg::bump(cnt_base.gas, item_ff.ptype == ktdc_pkg::TYPE_GAS);
      cnt_wdata.star  = ktdc_pkg::bump(cnt_base.star,
                                       (item_ff.ptype == ktdc_pkg::TYPE_STAR) && cfg.star_en);
      cnt_wdata.hole  = ktdc_pkg::bump(cnt_base.hole,
                                       (item_ff.ptype == ktdc_pkg::TYPE_HOLE) && cfg.hole_en);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      node_in      = node_ff;
      depth_in     = depth_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      leaf_in      = leaf_ff;
      task_in      = task_ff;
      cnt_addr_in  = cnt_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      node_we      = 1'b0;
      leaf_we      = 1'b0;
      cnt_we       = 1'b0;
      cnt_clear    = 1'b0;
      res          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (q_in.valid && out_free) begin
               q_pop   = 1'b1;
               item_in = q_in.item;
               case (q_in.item.kind)
                  ktdc_pkg::KIND_NODE: begin
                     node_we      = q_in.item.in_range;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = res;
                  end
                  ktdc_pkg::KIND_LEAF: begin
                     leaf_we      = q_in.item.in_range;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = res;
                  end
                  ktdc_pkg::KIND_WALK: begin
                     node_in  = '0;
                     depth_in = '0;
                     state_in = ST_NODE_RD;
                  end
                  ktdc_pkg::KIND_QUERY: begin
                     cnt_addr_in = query_ext[ktdc_pkg::TASK_AW-1:0];
                     state_in    = ST_QUERY_RD;
                  end
                  ktdc_pkg::KIND_CLEAR: begin
                     cnt_clear    = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = res;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = res;
                  end
               endcase
            end
         end
         ST_NODE_RD: begin
            state_in = ST_NODE_EVAL;
         end
         ST_NODE_EVAL: begin
            if (node_rd_ff.daughter[10]) begin
               leaf_in = node_rd_ff.leaf;
               if (ktdc_pkg::CMP_W'(node_rd_ff.leaf) >= ktdc_pkg::CMP_W'(ktdc_pkg::LEAF_COUNT)) begin
                  state_in = ST_ERR;
               end else begin
                  state_in = ST_LEAF_RD;
               end
            end else if ((depth_ff >= ktdc_pkg::DEPTH_W'(ktdc_pkg::MAX_DEPTH))
                         || (divisor == '0) || diff[63]) begin
               state_in = ST_ERR;
            end else begin
               rem_in   = diff[ktdc_pkg::KEY_W-1:0];
               dsh_in   = ktdc_pkg::WIDE_W'(divisor) << ktdc_pkg::Q_W;
               state_in = ST_DIV_CHK;
            end
         end
         ST_DIV_CHK: begin
            // A quotient of 2^Q_W or more cannot land inside the node table.
            if (fits) begin
               state_in = ST_ERR;
            end else begin
               dsh_in   = dsh_ff >> 1;
               quo_in   = '0;
               step_in  = ktdc_pkg::STEP_W'(ktdc_pkg::Q_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in = (quo_ff << 1) | ktdc_pkg::Q_W'(fits);
            if (fits) begin
               rem_in = rem_ff - dsh_ff[ktdc_pkg::KEY_W-1:0];
            end
            dsh_in = dsh_ff >> 1;
            if (step_ff == '0) begin
               state_in = ST_CHILD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_CHILD: begin
            if (child >= ktdc_pkg::CHILD_W'(ktdc_pkg::NODE_COUNT)) begin
               state_in = ST_ERR;
            end else begin
               node_in  = child[ktdc_pkg::NODE_AW-1:0];
               depth_in = depth_ff + 1'b1;
               state_in = ST_NODE_RD;
            end
         end
         ST_LEAF_RD: begin
            state_in = ST_LEAF_EVAL;
         end
         ST_LEAF_EVAL: begin
            task_in = leaf_rd_ff;
            if (task_ext >= ktdc_pkg::CMP_W'(ktdc_pkg::TASK_COUNT)) begin
               state_in = ST_ERR;
            end else if (leaf_rd_ff != cfg.local_task) begin
               cnt_addr_in = task_ext[ktdc_pkg::TASK_AW-1:0];
               state_in    = ST_CNT_RD;
            end else if (out_free) begin
               res.dest_task = leaf_rd_ff;
               res.dest_leaf = leaf_ff;
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res;
               state_in      = ST_IDLE;
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_UPD;
         end
         ST_CNT_UPD: begin
            if (out_free) begin
               cnt_we        = 1'b1;
               res.dest_task = task_ff;
               res.dest_leaf = leaf_ff;
               res.is_remote = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res;
               state_in      = ST_IDLE;
            end
         end
         ST_QUERY_RD: begin
            state_in = ST_QUERY_OUT;
         end
         ST_QUERY_OUT: begin
            if (out_free) begin
               if (item_ff.in_range) begin
                  res.count_total = 32'(cnt_base.total);
                  res.count_gas   = 32'(cnt_base.gas);
                  res.count_star  = 32'(cnt_base.star);
                  res.count_hole  = 32'(cnt_base.hole);
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = res;
               state_in     = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               res.walk_error = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_data_in    = res;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      node_ff     <= node_in;
      depth_ff    <= depth_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      leaf_ff     <= leaf_in;
      task_ff     <= task_in;
      cnt_addr_ff <= cnt_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_widx[ktdc_pkg::NODE_AW-1:0]] <= node_wdata;
      end
      node_rd_ff <= node_mem[node_ff];
   end

   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem[leaf_widx[ktdc_pkg::LEAF_AW-1:0]] <= q_in.item.leaf_task;
      end
      leaf_rd_ff <= leaf_mem[leaf_ridx[ktdc_pkg::LEAF_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_addr_ff] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_addr_ff];
   end

   // A counter set whose valid bit is clear reads as zero; clearing drops all bits.
   always_ff @(posedge clock) begin
      if (reset || cnt_clear) begin
         cnt_vld_ff <= '0;
      end else if (cnt_we) begin
         cnt_vld_ff[cnt_addr_ff] <= 1'b1;
      end
      cnt_vld_rd_ff <= cnt_vld_ff[cnt_addr_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/key_tree_destination_counter.sv]
// Top level of the key tree destination counter: ports, configuration and checks.
//
// Request transactions carry an op in req_tuser and the item fields in req_tdata.
// Op 0 loads a node of the key octree, op 1 loads a leaf owner, op 2 walks the
// tree from node 0 with a particle key and counts the particle for its owner
// task when that task is not the local one, op 3 reads a task's counters and
// op 4 clears all counters. Every request gives exactly one response, in order.
// The csr channel writes local_task and the star and black hole enables; it is
// always ready and should be used only while the block is idle.
// With the back end idle, table writes, clears and unused ops raise rsp_tvalid
// from its register once the back end takes the request; counter reads first
// pass through ST_QUERY_RD and ST_QUERY_OUT. Each walk level reads the node
// memory, then a restoring divider produces one quotient bit per cycle (10 bits
// for a 1024-node table). Items are worked one at a time; a two-entry queue
// keeps accepting requests while a walk is in progress, until it is full.
// Reset clears the counters at once through per-task valid bits; the node and
// leaf tables hold nothing until written. When rsp_tready is low the response
// holds in its register and the back end waits before finishing the next item.
module key_tree_destination_counter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // node_index, node_daughter, node_start_key, node_size, node_leaf,
   // leaf_index, leaf_task, particle_key, particle_type, task_query
   input  logic [ktdc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op
   input  logic [ktdc_pkg::OP_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // dest_task, dest_leaf, is_remote, count_total, count_gas, count_star,
   // count_hole
   output logic [ktdc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // walk_error
   output logic [0:0]                         rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ktdc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ktdc_pkg::CSR_DATA_W-1:0]    csr_data
);

   ktdc_pkg::cfg_type     cfg_ff;
   ktdc_pkg::q_link_type  q_link;
   logic                  q_pop;
   ktdc_pkg::result_type  rsp_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ktdc_pkg::CSR_LOCAL_TASK: cfg_ff.local_task <= csr_data;
            ktdc_pkg::CSR_STAR_EN:    cfg_ff.star_en    <= csr_data[0];
            ktdc_pkg::CSR_HOLE_EN:    cfg_ff.hole_en    <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   ktdc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_pop      (q_pop),
      .q_out      (q_link)
   );

   ktdc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q_link),
      .q_pop     (q_pop),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = {5'b0, rsp_data.count_hole, rsp_data.count_star,
                       rsp_data.count_gas, rsp_data.count_total, rsp_data.is_remote,
                       rsp_data.dest_leaf, rsp_data.dest_task};
   assign rsp_tuser = rsp_data.walk_error;

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_link.valid)
      else $error("back end took a transaction from an empty queue");

   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_error_has_no_dest: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[18:0] == '0))
      else $error("failed walk reported a destination");

endmodule
